// ----- hdl/lcd_rectangle_outline_stream_assert.svh -----
// Assertion macros for the checker file of the outline stream block.
`ifndef LCD_RECTANGLE_OUTLINE_STREAM_ASSERT_SVH
`define LCD_RECTANGLE_OUTLINE_STREAM_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define LRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define LRS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/lrs_pkg.sv -----
// Types and constants for the LCD rectangle outline stream block.
package lrs_pkg;

    // Field widths of the input and result transactions.
    localparam int ROW_W = 6;
    localparam int COL_W = 7;
    localparam int BANK_W = 3;
    localparam int BIT_W = 3;
    localparam int BYTE_W = 8;
    localparam int REP_W = 7;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;

    // Display limits.
    localparam logic [ROW_W-1:0] MAX_ROW = 6'd47;
    localparam logic [COL_W-1:0] MAX_COL = 7'd83;

    // Controller command bytes and the full-column data byte.
    localparam logic [BYTE_W-1:0] CMD_BANK = 8'h40;
    localparam logic [BYTE_W-1:0] CMD_COL = 8'h80;
    localparam logic [BYTE_W-1:0] DATA_FULL = 8'hFF;
    localparam logic [BYTE_W-1:0] DATA_ONE = 8'h01;

    // Write groups; each group is a bank command, a column command and one data byte.
    localparam logic [2:0] G_RUN_TOP = 3'd0;
    localparam logic [2:0] G_RUN_BOT = 3'd1;
    localparam logic [2:0] G_TL = 3'd2;
    localparam logic [2:0] G_TR = 3'd3;
    localparam logic [2:0] G_BL = 3'd4;
    localparam logic [2:0] G_BR = 3'd5;
    localparam logic [2:0] G_MID_L = 3'd6;
    localparam logic [2:0] G_MID_R = 3'd7;

    // Item position inside a group.
    localparam logic [1:0] PH_BANK = 2'd0;
    localparam logic [1:0] PH_COL = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    // Controller to datapath.
    typedef struct packed {
        logic              load;
        logic              emit;
        logic              last;
        logic [2:0]        kind;
        logic [1:0]        phase;
        logic [BANK_W-1:0] bank;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic              slot_free;
        logic              range_err;
        logic              has_mid;
        logic [BANK_W-1:0] mid_first;
        logic              mid_last;
    } t_status;

endpackage

// ----- hdl/lrs_datapath.sv -----
// Datapath: corner capture and ordering, item formation and the output register.
module lrs_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [lrs_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  lrs_pkg::t_cmd                  i_cmd,
    output lrs_pkg::t_status               o_status,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [lrs_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output logic [lrs_pkg::M_TUSER_W-1:0]  o_m_tuser,
    output logic                           o_m_tlast
);
    import lrs_pkg::*;

    logic [ROW_W-1:0]  in_r1, in_r2;
    logic [COL_W-1:0]  in_c1, in_c2;
    logic [ROW_W-1:0]  r_top, r_bot;
    logic [COL_W-1:0]  r_left, r_right;
    logic              r_err;
    logic [BANK_W-1:0] b1, b2;
    logic [BIT_W-1:0]  bit1, bit2;
    logic [REP_W-1:0]  run;
    logic [BYTE_W-1:0] top_mask, bot_mask;
    logic [BYTE_W:0]   bot_wide;
    logic [BANK_W-1:0] bank_sel;
    logic [COL_W-1:0]  col_sel;
    logic              it_data;
    logic [BYTE_W-1:0] it_byte;
    logic [REP_W-1:0]  it_rep;
    logic              r_valid;
    logic              r_is_data, r_range_err, r_last;
    logic [BYTE_W-1:0] r_byte;
    logic [REP_W-1:0]  r_rep;

    // Unpack the input transaction.
    assign in_r1 = i_s_tdata[5:0];
    assign in_c1 = i_s_tdata[12:6];
    assign in_r2 = i_s_tdata[18:13];
    assign in_c2 = i_s_tdata[25:19];

    // Capture the corners ordered top-left first, with the range check.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_top   <= (in_r1 > in_r2) ? in_r2 : in_r1;
            r_bot   <= (in_r1 > in_r2) ? in_r1 : in_r2;
            r_left  <= (in_c1 > in_c2) ? in_c2 : in_c1;
            r_right <= (in_c1 > in_c2) ? in_c1 : in_c2;
            r_err   <= (in_r1 > MAX_ROW) || (in_r2 > MAX_ROW) ||
                       (in_c1 > MAX_COL) || (in_c2 > MAX_COL);
        end
    end

    // Bank and bit of each corner row, the run length and the corner masks.
    assign b1 = r_top[ROW_W-1:BIT_W];
    assign b2 = r_bot[ROW_W-1:BIT_W];
    assign bit1 = r_top[BIT_W-1:0];
    assign bit2 = r_bot[BIT_W-1:0];
    assign run = r_right - r_left + 7'd1;
    assign top_mask = DATA_FULL << bit1;
    assign bot_wide = (9'd2 << bit2) - 9'd1;
    assign bot_mask = bot_wide[BYTE_W-1:0];

    // Status for the controller.
    assign o_status.slot_free = !r_valid || i_m_tready;
    assign o_status.range_err = r_err;
    assign o_status.has_mid = {1'b0, b2} > ({1'b0, b1} + 4'd1);
    assign o_status.mid_first = b1 + 3'd1;
    assign o_status.mid_last = (i_cmd.bank == (b2 - 3'd1));

    // Bank and column of the current group.
    always_comb begin
        unique case (i_cmd.kind)
            G_RUN_TOP, G_TL, G_TR: bank_sel = b1;
            G_RUN_BOT, G_BL, G_BR: bank_sel = b2;
            default:               bank_sel = i_cmd.bank;
        endcase
        unique case (i_cmd.kind)
            G_TR, G_BR, G_MID_R: col_sel = r_right;
            default:             col_sel = r_left;
        endcase
    end

    // Form the item for the current group and position.
    always_comb begin
        it_data = 1'b0;
        it_rep  = 7'd1;
        it_byte = CMD_BANK | {5'd0, bank_sel};
        unique case (i_cmd.phase)
            PH_BANK: it_byte = CMD_BANK | {5'd0, bank_sel};
            PH_COL:  it_byte = CMD_COL | {1'b0, col_sel};
            default: begin
                it_data = 1'b1;
                unique case (i_cmd.kind)
                    G_RUN_TOP: begin
                        it_byte = DATA_ONE << bit1;
                        it_rep  = run;
                    end
                    G_RUN_BOT: begin
                        it_byte = DATA_ONE << bit2;
                        it_rep  = run;
                    end
                    G_TL, G_TR: it_byte = top_mask;
                    G_BL, G_BR: it_byte = bot_mask;
                    default:    it_byte = DATA_FULL;
                endcase
            end
        endcase
    end

    // Output register; it holds a transaction until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_err) begin
                r_is_data   <= 1'b0;
                r_byte      <= '0;
                r_rep       <= '0;
                r_range_err <= 1'b1;
                r_last      <= 1'b1;
            end else begin
                r_is_data   <= it_data;
                r_byte      <= it_byte;
                r_rep       <= it_rep;
                r_range_err <= 1'b0;
                r_last      <= i_cmd.last;
            end
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata = {1'b0, r_rep, r_byte};
    assign o_m_tuser = {r_range_err, r_is_data};
    assign o_m_tlast = r_last;

endmodule

// ----- hdl/lrs_ctrl.sv -----
// Controller: steps through one rectangle's write groups, one item per cycle while the slot is free.
module lrs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  lrs_pkg::t_status  i_status,
    output lrs_pkg::t_cmd     o_cmd
);
    import lrs_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EMIT = 1'b1;

    logic              r_state, n_state;
    logic [2:0]        r_kind, n_kind;
    logic [1:0]        r_phase, n_phase;
    logic [BANK_W-1:0] r_bank, n_bank;
    logic              group_end;
    logic              last;

    assign group_end = (r_phase == PH_DATA);
    assign last = i_status.range_err ||
                  (group_end && (((r_kind == G_BR) && !i_status.has_mid) ||
                                 ((r_kind == G_MID_R) && i_status.mid_last)));

    assign o_s_tready = (r_state == S_IDLE);

    // Commands to the datapath.
    always_comb begin
        o_cmd.load  = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.emit  = (r_state == S_EMIT) && i_status.slot_free;
        o_cmd.last  = last;
        o_cmd.kind  = r_kind;
        o_cmd.phase = r_phase;
        o_cmd.bank  = r_bank;
    end

    // Sequencer over groups and positions.
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_phase = r_phase;
        n_bank  = r_bank;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EMIT;
                    n_kind  = G_RUN_TOP;
                    n_phase = PH_BANK;
                end
            end
            default: begin
                if (i_status.slot_free) begin
                    if (last) begin
                        n_state = S_IDLE;
                    end else if (!group_end) begin
                        n_phase = r_phase + 2'd1;
                    end else begin
                        n_phase = PH_BANK;
                        unique case (r_kind)
                            G_BR: begin
                                n_kind = G_MID_L;
                                n_bank = i_status.mid_first;
                            end
                            G_MID_L: n_kind = G_MID_R;
                            G_MID_R: begin
                                n_kind = G_MID_L;
                                n_bank = r_bank + 3'd1;
                            end
                            default: n_kind = r_kind + 3'd1;
                        endcase
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= G_RUN_TOP;
            r_phase <= PH_BANK;
            r_bank  <= '0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_phase <= n_phase;
            r_bank  <= n_bank;
        end
    end

endmodule

// ----- hdl/lcd_rectangle_outline_stream.sv -----
// Top level of the LCD rectangle outline stream block.
// A rectangle is taken and then sent as 18 to 42 result transactions, one per
// clock while the sink is ready: six groups of bank command, column command and data byte,
// plus two groups for each bank strictly between the top and bottom banks. The horizontal
// runs come as a single data item with a repeat count. A rectangle with a corner out of
// range gives one error transaction instead. The sequencer handles one rectangle at a time,
// and the next rectangle is taken as soon as its predecessor's final item sits in the
// output register.
module lcd_rectangle_outline_stream (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // first_row[5:0], first_col[12:6], second_row[18:13], second_col[25:19], zero pad
    input  logic [lrs_pkg::S_TDATA_W-1:0]  i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // out_byte[7:0], repeat_count[14:8], zero pad
    output logic [lrs_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // is_data[0], range_error[1]
    output logic [lrs_pkg::M_TUSER_W-1:0]  o_m_tuser,
    // last_item
    output logic                           o_m_tlast
);
    import lrs_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Group sequencer.
    lrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Corner registers, item formation and output register.
    lrs_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ----- hdl/lrs_checker.sv -----
// Port-level checks of the outline stream block, bound to its top level.
`include "lcd_rectangle_outline_stream_assert.svh"

module lrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // A stalled result transaction holds its contents.
    `LRS_ASSERT(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast), "stalled output changed")

    // An error transaction is the only one of its rectangle and carries nothing.
    `LRS_ASSERT(a_err_item, o_m_tvalid && o_m_tuser[1] |-> o_m_tlast && !o_m_tuser[0] && (o_m_tdata == 16'd0), "malformed error item")

    // Command bytes are always sent once.
    `LRS_ASSERT(a_cmd_once, o_m_tvalid && !o_m_tuser[0] && !o_m_tuser[1] |-> (o_m_tdata[14:8] == 7'd1), "command repeat count not one")

    // A rectangle just taken blocks the input until its final item is in the output register.
    `LRS_ASSERT(a_busy_after_take, i_s_tvalid && o_s_tready |=> !o_s_tready, "input taken while busy")

    // After reset no result is pending.
    `LRS_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_m_tvalid, "output valid after reset")

endmodule

bind lcd_rectangle_outline_stream lrs_checker u_lrs_checker (.*);
